// File: rtl/psc_pkg.sv
// Shared constants, operation and verdict codes, and interface types for the
// prime sieve chain. No dependencies.
package psc_pkg;

    localparam int CHAIN_DEPTH  = 64;
    localparam int NUMBER_WIDTH = 16;

    // Width of the tdata fields on both channels.
    localparam int FIELD_W = 16;
    // Working width of a number after masking to NUMBER_WIDTH.
    localparam int NUM_W   = (NUMBER_WIDTH < FIELD_W) ? NUMBER_WIDTH : FIELD_W;
    localparam int IDX_W   = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int COUNT_W = $clog2(CHAIN_DEPTH + 1);
    localparam int BIT_W   = $clog2(NUM_W);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Job operations handed from the front to the back.
    localparam logic [1:0] OP_TEST  = 2'd0;
    localparam logic [1:0] OP_SMALL = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Input kinds.
    localparam logic KIND_TEST = 1'b0;
    localparam logic KIND_STOP = 1'b1;

    // Result verdicts.
    localparam logic [1:0] VERDICT_PRIME     = 2'd0;
    localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
    localparam logic [1:0] VERDICT_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [NUM_W-1:0] number;
    } psc_job_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] count;
    } psc_status_t;

endpackage

// File: rtl/prime_sieve_chain.sv
// Top level of the prime sieve chain: front classifier, job queue and sieve
// back end. Depends on psc_pkg, psc_front, psc_queue and psc_back.
//
// Usage. Items enter on the s_axis channel: tuser carries the kind (test or
// stop), tdata carries the number. A test yields exactly one result item on
// the m_axis channel (tuser = verdict, tdata = tested number); a stop empties
// the chain of stored primes and yields nothing. Numbers are expected to
// arrive in increasing order from two, so the chain fills with the primes.
//
// Timing. The front takes an item in any cycle the four-entry queue has room.
// The back takes one job at a time: a test walks the stored primes in order;
// each costs a registered memory read, an equality compare and a bit-serial
// remainder of NUMBER_WIDTH steps. A number that no stored prime decides is
// then appended if the chain has room. Zero and one skip the walk. The result
// is loaded into the output register once that register is free.
//
// Reset clears the chain count, the queue and the output register; the prime
// store needs no clearing. When the receiver stalls, the finished result waits
// in the output register, the back holds its next verdict, and the queue keeps
// taking items until it is full, at which point s_axis_tready drops.
module prime_sieve_chain
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [FIELD_W-1:0] s_axis_tdata,  // [15:0] number
    input  logic               s_axis_tuser,  // [0] kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [FIELD_W-1:0] m_axis_tdata,  // [15:0] tested
    output logic [1:0]         m_axis_tuser   // [1:0] verdict
);

    logic        q_full;
    logic        q_push;
    psc_job_t    q_push_job;
    logic        q_valid;
    logic        q_ready;
    psc_job_t    q_job;
    psc_status_t status;

    psc_front u_front (
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .kind       (s_axis_tuser),
        .number     (s_axis_tdata),
        .queue_full (q_full),
        .push       (q_push),
        .push_job   (q_push_job)
    );

    psc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_job   (q_job)
    );

    psc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job_ready   (q_ready),
        .job         (q_job),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_verdict (m_axis_tuser),
        .out_tested  (m_axis_tdata),
        .status      (status)
    );

    // The chain never holds more primes than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= COUNT_W'(CHAIN_DEPTH))
        else $error("prime chain count exceeds its depth");

    // A stop taken by the back empties the chain on the next cycle.
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_job.op == OP_STOP) |=> (status.count == '0))
        else $error("stop did not clear the prime chain");

    // The chain grows by one prime at a time or is cleared.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (status.count != $past(status.count)) |->
            (status.count == $past(status.count) + COUNT_W'(1) || status.count == '0))
        else $error("prime chain count jumped");

    // The back only takes a job while idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |-> !status.busy)
        else $error("job taken while the back was busy");

endmodule

// File: rtl/psc_front.sv
// Front end of the prime sieve chain: masks the number and classifies each
// input item into a job. Depends on psc_pkg.
module psc_front
    import psc_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [FIELD_W-1:0] number,
    input  logic               queue_full,
    output logic               push,
    output psc_job_t           push_job
);

    logic [NUM_W-1:0] num;

    assign num      = number[NUM_W-1:0];
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_job.number = num;
        // Zero and one never reach the chain: they are composite outright.
        if (kind == KIND_STOP)
        begin
            push_job.op = OP_STOP;
        end
        else if (num < NUM_W'(2))
        begin
            push_job.op = OP_SMALL;
        end
        else
        begin
            push_job.op = OP_TEST;
        end
    end

endmodule

// File: rtl/psc_queue.sv
// Short job queue between the front and the back of the prime sieve chain.
// Depends on psc_pkg.
module psc_queue
    import psc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  psc_job_t push_job,
    output logic     full,
    output logic     pop_valid,
    input  logic     pop_ready,
    output psc_job_t pop_job
);

    psc_job_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                pop;

    assign full      = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/psc_back.sv
// Back end of the prime sieve chain: walks the stored primes, runs a bit-serial
// remainder against each, appends new primes and drives the output register.
// Depends on psc_pkg.
module psc_back
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  psc_job_t           job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_verdict,
    output logic [FIELD_W-1:0] out_tested,
    output psc_status_t        status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [1:0]         verdict_reg, verdict_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_verdict_reg;
    logic [NUM_W-1:0]   out_tested_reg;

    logic [NUM_W-1:0]   prime_mem [CHAIN_DEPTH];
    logic [NUM_W-1:0]   rd_data_reg;

    logic               mem_we;
    logic               out_load;
    logic               can_load;
    logic [NUM_W:0]     partial;
    logic [NUM_W:0]     partial_sub;
    logic [NUM_W-1:0]   rem_step;
    logic [COUNT_W-1:0] idx_plus;

    // One restoring-division step, most significant dividend bit first.
    assign partial     = {rem_reg, num_reg[bit_reg]};
    assign partial_sub = partial - {1'b0, rd_data_reg};
    assign rem_step    = (partial >= {1'b0, rd_data_reg}) ? partial_sub[NUM_W-1:0]
                                                          : partial[NUM_W-1:0];
    assign idx_plus    = idx_reg + COUNT_W'(1);
    assign can_load    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        verdict_next = verdict_reg;
        mem_we       = 1'b0;
        out_load     = 1'b0;
        job_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    num_next = job.number;
                    idx_next = '0;
                    unique case (job.op)
                        OP_STOP:
                        begin
                            count_next = '0;
                        end
                        OP_SMALL:
                        begin
                            verdict_next = VERDICT_COMPOSITE;
                            state_next   = ST_DONE;
                        end
                        OP_TEST:
                        begin
                            state_next = (count_reg == '0) ? ST_TAIL : ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (num_reg == rd_data_reg)
                begin
                    verdict_next = VERDICT_PRIME;
                    state_next   = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = BIT_W'(NUM_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        verdict_next = VERDICT_COMPOSITE;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_plus;
                        state_next = (idx_plus == count_reg) ? ST_TAIL : ST_READ;
                    end
                end
            end
            ST_TAIL:
            begin
                if (count_reg < COUNT_W'(CHAIN_DEPTH))
                begin
                    mem_we       = 1'b1;
                    count_next   = count_reg + COUNT_W'(1);
                    verdict_next = VERDICT_PRIME;
                end
                else
                begin
                    verdict_next = VERDICT_FULL;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (can_load)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        idx_reg     <= idx_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        verdict_reg <= verdict_next;
        if (out_load)
        begin
            out_verdict_reg <= verdict_reg;
            out_tested_reg  <= num_reg;
        end
    end

    // Prime store: one write port at the tail, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prime_mem[count_reg[IDX_W-1:0]] <= num_reg;
        end
        rd_data_reg <= prime_mem[idx_reg[IDX_W-1:0]];
    end

    assign out_valid    = out_valid_reg;
    assign out_verdict  = out_verdict_reg;
    assign out_tested   = FIELD_W'(out_tested_reg);
    assign status.busy  = (state_reg != ST_IDLE);
    assign status.count = count_reg;

endmodule

// File: dv/psc_verdict_check.sv
`timescale 1ns / 1ps
// Verdict checker for the prime sieve chain: watches both streams, predicts each verdict
// from its own copy of the stored primes, and compares. Depends on psc_pkg.
module psc_verdict_check
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [FIELD_W-1:0] s_axis_tdata,
    input  logic               s_axis_tuser,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [FIELD_W-1:0] m_axis_tdata,
    input  logic [1:0]         m_axis_tuser,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [1:0]         verdict;
        logic [FIELD_W-1:0] tested;
    } verdict_item_t;

    logic [NUM_W-1:0] known_primes [CHAIN_DEPTH];
    int               known_count = 0;
    verdict_item_t    awaited_verdicts [$];
    verdict_item_t    oldest;
    verdict_item_t    fresh;
    int               fail_total = 0;
    int               awaiting = 0;

    assign fail_count = fail_total;
    assign pending    = awaiting;

    // Walks the chain in order; the first stored prime that is equal or divides decides.
    function automatic logic [1:0] sieve_verdict(input logic [NUM_W-1:0] num);
        logic [1:0] verdict;
        bit         decided;
        int         i;
        verdict = VERDICT_FULL;
        decided = 1'b0;
        if (num < 2)
        begin
            verdict = VERDICT_COMPOSITE;
            decided = 1'b1;
        end
        for (i = 0; i < known_count && !decided; i++)
        begin
            if (num == known_primes[i])
            begin
                verdict = VERDICT_PRIME;
                decided = 1'b1;
            end
            else if (num % known_primes[i] == 0)
            begin
                verdict = VERDICT_COMPOSITE;
                decided = 1'b1;
            end
        end
        if (!decided && known_count < CHAIN_DEPTH)
        begin
            known_primes[known_count] = num;
            known_count++;
            verdict = VERDICT_PRIME;
        end
        return verdict;
    endfunction

    function automatic void flag_failure(input string what);
        fail_total++;
        if (fail_total <= 10)
            $display("%t psc_verdict_check: %s", $realtime, what);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_count = 0;
            awaited_verdicts.delete();
            awaiting = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    flag_failure($sformatf("unexpected result verdict=%0d tested=%0d",
                                           m_axis_tuser, m_axis_tdata));
                end
                else
                begin
                    oldest = awaited_verdicts.pop_front();
                    if (m_axis_tuser !== oldest.verdict || m_axis_tdata !== oldest.tested)
                        flag_failure($sformatf({"mismatch: expected verdict=%0d tested=%0d,",
                                                " got verdict=%0d tested=%0d"},
                                               oldest.verdict, oldest.tested,
                                               m_axis_tuser, m_axis_tdata));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == KIND_STOP)
                begin
                    known_count = 0;
                end
                else
                begin
                    fresh.verdict = sieve_verdict(s_axis_tdata[NUM_W-1:0]);
                    fresh.tested  = FIELD_W'(s_axis_tdata[NUM_W-1:0]);
                    awaited_verdicts.push_back(fresh);
                end
            end
            awaiting = awaited_verdicts.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the prime sieve chain testbench: clock, reset, stream stimulus and verdict.
// Depends on psc_pkg, prime_sieve_chain and psc_verdict_check.
module tb_top
    import psc_pkg::*;
();

    // Number of input items after which the random part stops.
    localparam int ITEM_TARGET = 500;
    // Length of the one long receiver hold-off, in cycles, and when it starts.
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [FIELD_W-1:0] s_axis_tdata = '0;   // [15:0] number
    logic               s_axis_tuser = 1'b0; // [0] kind
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [FIELD_W-1:0] m_axis_tdata;        // [15:0] tested
    logic [1:0]         m_axis_tuser;        // [1:0] verdict

    int   items_in = 0;
    int   fail_count;
    int   pending;
    logic calm;

    // A window of items in which neither side idles, so the back end runs flat out.
    assign calm = (items_in >= 250) && (items_in < 330);

    always #10 clk = ~clk;

    prime_sieve_chain u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    psc_verdict_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Offers one item, starting at a falling edge. Random idle cycles come first,
    // then the item is held until a rising edge sees tready, and the task returns
    // at the next falling edge. Valid is only ever assigned once per time step.
    task automatic offer_item(input logic kind, input logic [FIELD_W-1:0] num);
        while (!calm && $urandom_range(99) < 34)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= num;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        items_in++;
        @(negedge clk);
    endtask

    // A well-formed sieve run: clear the chain, then count up from two. With a step
    // above one, numbers are skipped now and then, so the chain also sees gaps.
    task automatic sieve_run(input int last, input int max_step);
        int num;
        offer_item(KIND_STOP, FIELD_W'($urandom));
        num = 2;
        while (num <= last)
        begin
            offer_item(KIND_TEST, FIELD_W'(num));
            if (max_step > 1 && $urandom_range(3) == 0)
                num += $urandom_range(max_step, 2);
            else
                num++;
        end
    endtask

    // Fills the chain to its depth: two and then only odd numbers, so every prime
    // up to the last is stored in order. The 64th prime is 311, so anything past
    // it that no stored prime decides comes back as chain full.
    task automatic fill_chain(input int last);
        int num;
        offer_item(KIND_STOP, FIELD_W'($urandom));
        offer_item(KIND_TEST, FIELD_W'(2));
        for (num = 3; num <= last; num += 2)
            offer_item(KIND_TEST, FIELD_W'(num));
        offer_item(KIND_TEST, FIELD_W'(65521));
        repeat (3)
            offer_item(KIND_TEST, FIELD_W'($urandom_range(65535, 312)));
    endtask

    // Out-of-order noise: full-range numbers, numbers below two and stray stops.
    task automatic noise_item();
        case ($urandom_range(9))
            0:       offer_item(KIND_STOP, FIELD_W'($urandom));
            1:       offer_item(KIND_TEST, FIELD_W'($urandom_range(1, 0)));
            default: offer_item(KIND_TEST, FIELD_W'($urandom_range(65535, 0)));
        endcase
    endtask

    // Receiver. Mostly random stalls; once, early on, a long hold-off while the
    // sender keeps offering, so the queue fills up and s_axis_tready drops.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && items_in >= HOLD_AT)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else if (calm)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= 34);
            end
        end
    end

    initial
    begin : stimulus
        int pick;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. A stop on the empty chain, zero and one, the first primes
        // and their multiples, a repeat of a stored prime, the all-ones number, the
        // largest 16-bit prime stored and then matched, and composites whose factors
        // were never stored (121 and 143 land in the chain as primes).
        offer_item(KIND_STOP, FIELD_W'(0));
        offer_item(KIND_TEST, FIELD_W'(0));
        offer_item(KIND_TEST, FIELD_W'(1));
        for (int num = 2; num <= 9; num++)
            offer_item(KIND_TEST, FIELD_W'(num));
        offer_item(KIND_TEST, FIELD_W'(2));
        offer_item(KIND_TEST, FIELD_W'(7));
        offer_item(KIND_TEST, FIELD_W'(1));
        offer_item(KIND_TEST, FIELD_W'(0));
        offer_item(KIND_TEST, FIELD_W'(65535));
        offer_item(KIND_TEST, FIELD_W'(65521));
        offer_item(KIND_TEST, FIELD_W'(65521));
        offer_item(KIND_TEST, FIELD_W'(121));
        offer_item(KIND_TEST, FIELD_W'(143));
        offer_item(KIND_STOP, FIELD_W'(16'hFFFF));
        offer_item(KIND_STOP, FIELD_W'(0));
        offer_item(KIND_TEST, FIELD_W'(2));
        offer_item(KIND_TEST, FIELD_W'(4));

        // Random part: one forced fill of the whole chain, then a mix of short runs
        // (most of the traffic), occasional full fills and bursts of noise.
        fill_chain($urandom_range(360, 320));
        while (items_in < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                fill_chain($urandom_range(340, 312));
            end
            else if (pick < 72)
            begin
                sieve_run($urandom_range(40, 3), 3);
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                    noise_item();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every test gives one result; a trailing stop gives none but may
        // still be in flight, so a short tail follows.
        while (pending != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Run limit: 100 ms, several times the slowest correct run (every test walking a
    // full chain, plus the hold-off and random stalls on both sides).
    initial
    begin : watchdog
        #100_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: prime_sieve_chain.f
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_queue.sv
rtl/psc_back.sv
rtl/prime_sieve_chain.sv
dv/psc_verdict_check.sv
dv/tb_top.sv
